// File: hdl/assert_macros.svh
// Assertion helpers; the bodies are empty when SYNTH is defined.
// Both macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// File: hdl/mtfl_pkg.sv
package mtfl_pkg;

  localparam int DEPTH       = 8;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

// File: hdl/mtfl_ctrl.sv
module mtfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mtfl_pkg::dp_cmd_t cmd
);

  mtfl_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtfl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd.exec   = 1'b0;
    case (state_r)
      mtfl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = mtfl_pkg::ST_RESP;
        end
      end
      mtfl_pkg::ST_RESP: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = mtfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtfl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/mtfl_datapath.sv
`include "assert_macros.svh"

module mtfl_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mtfl_pkg::dp_cmd_t          cmd,
  input  mtfl_pkg::action_t          action,
  input  logic [mtfl_pkg::KEY_W-1:0] key,
  input  logic [mtfl_pkg::IDX_W-1:0] index,
  output logic [mtfl_pkg::KEY_W-1:0] entry_key,
  output logic                       out_of_range,
  output logic                       was_present,
  output logic [mtfl_pkg::CNT_W-1:0] entry_count
);

  logic [mtfl_pkg::KEY_W-1:0] keys_r   [mtfl_pkg::DEPTH];
  logic [mtfl_pkg::KEY_W-1:0] keys_nxt [mtfl_pkg::DEPTH];
  logic [mtfl_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [mtfl_pkg::KEY_W-1:0] key_res_r, key_res_nxt;
  logic                       oor_r, oor_nxt;
  logic                       present_r, present_nxt;

  logic [mtfl_pkg::DEPTH-1:0] match;
  logic [mtfl_pkg::CNT_W-1:0] top;
  logic [mtfl_pkg::CNT_W-1:0] index_ext;

  assign index_ext = mtfl_pkg::CNT_W'(index);

  always_comb begin
    for (int i = 0; i < mtfl_pkg::DEPTH; i++) begin
      match[i] = (mtfl_pkg::CNT_W'(i) < count_r) && (keys_r[i] == key);
    end
  end

  // highest position that takes its upper neighbor; lowest match wins
  always_comb begin
    if (count_r < mtfl_pkg::CNT_W'(mtfl_pkg::DEPTH)) begin
      top = count_r;
    end else begin
      top = mtfl_pkg::CNT_W'(mtfl_pkg::DEPTH - 1);
    end
    for (int i = mtfl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        top = mtfl_pkg::CNT_W'(i);
      end
    end
  end

  always_comb begin
    keys_nxt    = keys_r;
    count_nxt   = count_r;
    key_res_nxt = key_res_r;
    oor_nxt     = oor_r;
    present_nxt = present_r;
    if (cmd.exec) begin
      if (action == mtfl_pkg::ACT_READ) begin
        present_nxt = 1'b0;
        if (index_ext < count_r) begin
          oor_nxt     = 1'b0;
          key_res_nxt = keys_r[index];
        end else begin
          oor_nxt     = 1'b1;
          key_res_nxt = '0;
        end
      end else begin
        oor_nxt     = 1'b0;
        present_nxt = |match;
        key_res_nxt = key;
        if (!(|match) && (count_r < mtfl_pkg::CNT_W'(mtfl_pkg::DEPTH))) begin
          count_nxt = count_r + 1'b1;
        end
        keys_nxt[0] = key;
        for (int j = 1; j < mtfl_pkg::DEPTH; j++) begin
          if (mtfl_pkg::CNT_W'(j) <= top) begin
            keys_nxt[j] = keys_r[j-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    keys_r    <= keys_nxt;
    key_res_r <= key_res_nxt;
    oor_r     <= oor_nxt;
    present_r <= present_nxt;
  end

  assign entry_key    = key_res_r;
  assign out_of_range = oor_r;
  assign was_present  = present_r;
  assign entry_count  = count_r;

  `ASSERT_ALWAYS(a_count_bound, count_r <= mtfl_pkg::CNT_W'(mtfl_pkg::DEPTH))
  `ASSERT_NEXT(a_count_idle, !cmd.exec, $stable(count_r))
  `ASSERT_NEXT(a_count_read, cmd.exec && action == mtfl_pkg::ACT_READ, $stable(count_r))
  `ASSERT_NEXT(a_hit_keeps_count, cmd.exec && action == mtfl_pkg::ACT_ADD && (|match),
               $stable(count_r) && present_r)

endmodule

// File: hdl/move_to_front_recent_list_top.sv
// Most-recently-used list of up to eight 64-bit keys, position 0 the newest.
// An add (tuser = 0) searches all entries in parallel, moves a found key to
// the top or pushes a new one in (dropping the oldest when full) and returns
// the key with the hit flag; a read (tuser = 1) returns the key at the index
// or flags out_of_range when the index is not below the count. The entry
// registers update and the result register loads in the accept cycle, and
// the result is offered on the next; the next input is taken only once that
// result has been accepted, so transactions never overlap. Entries never
// written hold no defined value and cannot be read.
module move_to_front_recent_list_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mtfl_pkg::IN_TDATA_W-1:0]  in_tdata,  // key[63:0], index[66:64], zero pad
  input  logic [0:0]                       in_tuser,  // action[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mtfl_pkg::OUT_TDATA_W-1:0] out_tdata  // entry_key[63:0], out_of_range[64],
                                                      // was_present[65], entry_count[69:66],
                                                      // zero pad
);

  localparam int PadW = mtfl_pkg::OUT_TDATA_W - mtfl_pkg::KEY_W - 2 - mtfl_pkg::CNT_W;

  mtfl_pkg::dp_cmd_t          cmd;
  mtfl_pkg::action_t          action;
  logic [mtfl_pkg::KEY_W-1:0] entry_key;
  logic                       out_of_range;
  logic                       was_present;
  logic [mtfl_pkg::CNT_W-1:0] entry_count;

  assign action = mtfl_pkg::action_t'(in_tuser[0]);

  mtfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mtfl_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .action       (action),
    .key          (in_tdata[mtfl_pkg::KEY_W-1:0]),
    .index        (in_tdata[mtfl_pkg::KEY_W +: mtfl_pkg::IDX_W]),
    .entry_key    (entry_key),
    .out_of_range (out_of_range),
    .was_present  (was_present),
    .entry_count  (entry_count)
  );

  assign out_tdata = {{PadW{1'b0}}, entry_count, was_present, out_of_range, entry_key};

endmodule
